FILE: rtl/lbse_pkg.sv
// Shared types, constants and breakpoint tables of the lead battery charge estimator.
`default_nettype none

package lbse_pkg;

  // Field and register widths
  localparam int unsigned SAMPLE_W      = 10;
  localparam int unsigned HELD_W        = 14;
  localparam int unsigned POINT_W       = 13;
  localparam int unsigned SOC_W         = 7;
  localparam int unsigned CELL_W        = 10;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 2;
  localparam int unsigned SEG_W         = 4;
  localparam int unsigned DEN_W         = 9;
  localparam int unsigned REM_W         = 12;
  localparam int unsigned QUO_W         = 4;
  localparam int unsigned MAGIC_W       = 17;
  localparam int unsigned PROD_W        = HELD_W + MAGIC_W;
  localparam int unsigned MAGIC_SHIFT   = 20;

  localparam int unsigned WINDOW_DEPTH_DEF = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BATTERY_KIND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_SEL   = 1'b1;

  // Battery kinds
  localparam logic [KIND_W-1:0] KIND_A48      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_B48      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_A72      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNLISTED = 2'd3;

  // Reciprocals scaled by 2^20, exact for every 14-bit dividend
  localparam logic [MAGIC_W-1:0] MAGIC_DIV13 = 17'd80660;
  localparam logic [MAGIC_W-1:0] MAGIC_DIV21 = 17'd49933;
  localparam logic [MAGIC_W-1:0] MAGIC_DIV22 = 17'd47663;

  localparam logic [SEG_W-1:0] STARTUP_POINT = 4'd9;
  localparam logic [SEG_W-1:0] LAST_POINT_10 = 4'd9;
  localparam logic [SEG_W-1:0] LAST_POINT_11 = 4'd10;
  localparam logic [SOC_W-1:0] SOC_FULL      = 7'd100;

  // Breakpoint tables in centivolts
  localparam logic [POINT_W-1:0] TBL_A48 [11] = '{
    13'd4400, 13'd4540, 13'd4632, 13'd4708, 13'd4767, 13'd4840,
    13'd4904, 13'd4960, 13'd5016, 13'd5068, 13'd5068};
  localparam logic [POINT_W-1:0] TBL_B48 [11] = '{
    13'd4351, 13'd4562, 13'd4643, 13'd4710, 13'd4760, 13'd4810,
    13'd4860, 13'd4909, 13'd4948, 13'd4976, 13'd4990};
  localparam logic [POINT_W-1:0] TBL_B48C [11] = '{
    13'd4562, 13'd4643, 13'd4884, 13'd4940, 13'd5192, 13'd5340,
    13'd5490, 13'd5550, 13'd5652, 13'd5780, 13'd5980};
  localparam logic [POINT_W-1:0] TBL_A72 [11] = '{
    13'd6600, 13'd6810, 13'd6948, 13'd7062, 13'd7164, 13'd7260,
    13'd7356, 13'd7440, 13'd7524, 13'd7602, 13'd7602};

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD,
    ST_SEEK,
    ST_DIV,
    ST_DONE
  } ctl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic hold;
    logic seek;
    logic div;
    logic emit;
  } lbse_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_last;
    logic seek_done;
    logic div_done;
  } lbse_sts_t;

  // Look up one breakpoint of the selected table
  function automatic logic [POINT_W-1:0] table_point(input logic [KIND_W-1:0] kind,
                                                     input logic sel,
                                                     input logic [SEG_W-1:0] idx);
    logic [POINT_W-1:0] pt;
    pt = '0;
    if (idx <= LAST_POINT_11) begin
      unique case (kind)
        KIND_B48: pt = sel ? TBL_B48C[idx] : TBL_B48[idx];
        KIND_A72: pt = TBL_A72[idx];
        default:  pt = TBL_A48[idx];
      endcase
    end
    return pt;
  endfunction

  // Index of the last breakpoint of the selected table
  function automatic logic [SEG_W-1:0] last_point(input logic [KIND_W-1:0] kind);
    return (kind == KIND_B48) ? LAST_POINT_11 : LAST_POINT_10;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lbse_ctrl.sv
// Sequencing state machine of the lead battery charge estimator.
`default_nettype none

module lbse_ctrl
  import lbse_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  input  wire lbse_sts_t sts_i,
  output lbse_cmd_t      cmd_o
);

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i)      state_d = ST_SCAN;
      ST_SCAN: if (sts_i.scan_last) state_d = ST_HOLD;
      ST_HOLD:                      state_d = ST_SEEK;
      ST_SEEK: if (sts_i.seek_done) state_d = ST_DIV;
      ST_DIV:  if (sts_i.div_done)  state_d = ST_DONE;
      ST_DONE: if (out_free)        state_d = ST_IDLE;
      default:                      state_d = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: cmd_o.scan = 1'b1;
      ST_HOLD: cmd_o.hold = 1'b1;
      ST_SEEK: cmd_o.seek = 1'b1;
      ST_DIV:  cmd_o.div  = !sts_i.div_done;
      ST_DONE: begin
        cmd_o.emit = out_free;
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/lbse_datapath.sv
// Window, held voltage, table search, divider and output registers of the estimator.
`default_nettype none

module lbse_datapath
  import lbse_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [SAMPLE_W-1:0]   voltage_decivolts_i,
  input  wire logic                  startup_phase_i,
  input  wire logic                  vehicle_still_i,
  input  wire lbse_cmd_t             cmd_i,
  output lbse_sts_t                  sts_o,
  output logic [SOC_W-1:0]           soc_percent_o,
  output logic [HELD_W-1:0]          held_voltage_cv_o,
  output logic [CELL_W-1:0]          min_cell_cv_o,
  output logic [CELL_W-1:0]          max_cell_cv_o
);

  localparam int unsigned IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);

  // Configuration registers
  logic [KIND_W-1:0] kind_q;
  logic              sel_q;

  // Window and scan state
  logic [SAMPLE_W-1:0] win_q [WINDOW_DEPTH];
  logic [IDX_W-1:0]    wr_idx_q, scan_idx_q;
  logic [SAMPLE_W-1:0] wmax_q, scan_word;
  logic                startup_q, still_q;

  // Held voltage and estimate state
  logic [HELD_W-1:0]  held_q;
  logic [SEG_W-1:0]   seg_q;
  logic [SOC_W-1:0]   base_q;
  logic [REM_W-1:0]   rem_q;
  logic [DEN_W-1:0]   den_q;
  logic [QUO_W-1:0]   quo_q;
  logic [PROD_W-1:0]  prod_min_q, prod_max_q;
  logic [MAGIC_W-1:0] magic_min, magic_max;

  // Table search terms
  logic [POINT_W-1:0] pt_lo, pt_hi, pt_first, pt_last, pt_start, span;
  logic [HELD_W-1:0]  offset, held_scaled;
  logic [DEN_W-1:0]   off_narrow;
  logic               below, above, hit;

  assign scan_word = win_q[scan_idx_q];

  assign pt_lo    = table_point(kind_q, sel_q, seg_q);
  assign pt_hi    = table_point(kind_q, sel_q, seg_q + 4'd1);
  assign pt_first = table_point(kind_q, sel_q, '0);
  assign pt_last  = table_point(kind_q, sel_q, last_point(kind_q));
  assign pt_start = table_point(kind_q, sel_q, STARTUP_POINT);
  assign span     = pt_hi - pt_lo;
  assign offset   = held_q - HELD_W'(pt_lo);
  assign off_narrow  = offset[DEN_W-1:0];
  assign held_scaled = (HELD_W'(wmax_q) << 3) + (HELD_W'(wmax_q) << 1);

  assign below = held_q < HELD_W'(pt_first);
  assign above = held_q >= HELD_W'(pt_last);
  assign hit   = held_q < HELD_W'(pt_hi);

  assign sts_o.scan_last = scan_idx_q == IDX_LAST;
  assign sts_o.seek_done = below || above || hit;
  assign sts_o.div_done  = rem_q < REM_W'(den_q);

  // Pick reciprocals for the cell divisions
  assign magic_min = MAGIC_DIV22;
  assign magic_max = (kind_q == KIND_UNLISTED) ? MAGIC_DIV21 : MAGIC_DIV13;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_A48;
      sel_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BATTERY_KIND: kind_q <= cfg_data_i;
        REG_CHARGE_SEL:   sel_q  <= cfg_data_i[0];
        default:          kind_q <= kind_q;
      endcase
    end
  end

  // Store sample, update held voltage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_q[i] <= '0;
      end
      wr_idx_q <= '0;
      held_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        win_q[wr_idx_q] <= voltage_decivolts_i;
        wr_idx_q        <= (wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + 1'b1;
      end
      if (cmd_i.hold) begin
        if (startup_q) begin
          held_q <= HELD_W'(pt_start);
        end else if (still_q) begin
          held_q <= held_scaled;
        end
      end
    end
  end

  // Scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      scan_idx_q <= '0;
      wmax_q     <= '0;
      startup_q  <= startup_phase_i;
      still_q    <= vehicle_still_i;
    end else if (cmd_i.scan) begin
      scan_idx_q <= (scan_idx_q == IDX_LAST) ? '0 : scan_idx_q + 1'b1;
      if (scan_word > wmax_q) begin
        wmax_q <= scan_word;
      end
    end
  end

  // Walk segments, then divide by repeated subtraction
  always_ff @(posedge clk_i) begin
    if (cmd_i.hold) begin
      seg_q <= '0;
    end else if (cmd_i.seek) begin
      quo_q <= '0;
      priority if (below) begin
        base_q <= '0;
        rem_q  <= '0;
        den_q  <= DEN_W'(1);
      end else if (above) begin
        base_q <= SOC_FULL;
        rem_q  <= '0;
        den_q  <= DEN_W'(1);
      end else if (hit) begin
        base_q <= (SOC_W'(seg_q) << 3) + (SOC_W'(seg_q) << 1);
        rem_q  <= (REM_W'(off_narrow) << 3) + (REM_W'(off_narrow) << 1);
        den_q  <= span[DEN_W-1:0];
      end else begin
        seg_q <= seg_q + 1'b1;
      end
    end else if (cmd_i.div) begin
      rem_q <= rem_q - REM_W'(den_q);
      quo_q <= quo_q + 1'b1;
    end
  end

  // Multiply held voltage by the cell reciprocals
  always_ff @(posedge clk_i) begin
    prod_min_q <= PROD_W'(held_q) * PROD_W'(magic_min);
    prod_max_q <= PROD_W'(held_q) * PROD_W'(magic_max);
  end

  // Load output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      soc_percent_o     <= base_q + SOC_W'(quo_q);
      held_voltage_cv_o <= held_q;
      max_cell_cv_o     <= prod_max_q[MAGIC_SHIFT +: CELL_W];
      if (kind_q == KIND_UNLISTED) begin
        min_cell_cv_o <= prod_min_q[MAGIC_SHIFT +: CELL_W];
      end else begin
        min_cell_cv_o <= held_q[HELD_W-1:4];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lead_battery_soc_estimator.sv
// Top level of the lead battery state-of-charge estimator.
// Usage: one pack-voltage word per second enters on in_valid_i / in_stall_o
// with voltage_decivolts_i, startup_phase_i and vehicle_still_i; it is taken
// at a clock edge with valid high and stall low. Each word yields exactly one
// result word on out_valid_o / out_stall_i: state of charge, held voltage and
// min/max cell voltage.
// An item passes through these steps in order: the window maximum is found
// by stepping one entry a cycle, the held voltage is updated, the breakpoint
// segment walk runs, and the repeated-subtraction divider yields the
// fractional tenth. The window is WINDOW_DEPTH deep, 10 by default.
// One item is in work at a time.
// The output register holds the last result while a new word is accepted;
// when the receiver stalls, the finished next result waits in the datapath
// registers until the output register frees; the input stalls meanwhile.
// Reset clears the sample window, write index, held voltage, configuration
// (48V type A resting table) and output valid. Configuration must be written
// via cfg_we_i/cfg_index_i/cfg_data_i while idle; the block does not check it.
`default_nettype none

module lead_battery_soc_estimator
  import lbse_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [SAMPLE_W-1:0]   voltage_decivolts_i,
  input  wire logic                  startup_phase_i,
  input  wire logic                  vehicle_still_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [SOC_W-1:0]           soc_percent_o,
  output logic [HELD_W-1:0]          held_voltage_cv_o,
  output logic [CELL_W-1:0]          min_cell_cv_o,
  output logic [CELL_W-1:0]          max_cell_cv_o
);

  lbse_cmd_t cmd;
  lbse_sts_t sts;

  lbse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lbse_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .voltage_decivolts_i (voltage_decivolts_i),
    .startup_phase_i     (startup_phase_i),
    .vehicle_still_i     (vehicle_still_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .soc_percent_o       (soc_percent_o),
    .held_voltage_cv_o   (held_voltage_cv_o),
    .min_cell_cv_o       (min_cell_cv_o),
    .max_cell_cv_o       (max_cell_cv_o)
  );

endmodule

`default_nettype wire
